// ===== design/rpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the region protection table: sizes, command codes,
// cell operations and the request token that walks the cell chains.
// No dependencies.
package rpt_pkg;

    localparam int REGION_SLOTS = 16;
    localparam int GUARD_SLOTS  = 8;
    localparam int ADDR_BITS    = 48;
    localparam int LIM_W        = ADDR_BITS + 1;
    localparam int CMD_W        = 3;
    localparam int PERM_W       = 8;
    localparam int MAX_SLOTS    = (REGION_SLOTS > GUARD_SLOTS) ? REGION_SLOTS : GUARD_SLOTS;
    localparam int SLOT_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [CMD_W-1:0] CMD_ADD_REGION    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_REGION = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK_ACCESS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GUARD_QUERY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_GUARD     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_GUARD   = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_PROBE  = 3'd1,
        OP_WRITE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CHECK  = 3'd4,
        OP_QUERY  = 3'd5,
        OP_ALLOC  = 3'd6
    } cell_op_t;

    // hit: clash / found / first holder seen / slot taken, depending on op
    typedef struct packed {
        cell_op_t                op;
        logic [ADDR_BITS-1:0]    addr;
        logic [LIM_W-1:0]        lim;
        logic [PERM_W-1:0]       perms;
        logic                    hit;
        logic                    grant;
        logic                    match_ok;
        logic [SLOT_W-1:0]       match_idx;
        logic                    free_ok;
        logic [SLOT_W-1:0]       free_idx;
    } tok_t;

endpackage

// ===== design/rpt_in_if.sv =====
`timescale 1ns / 1ps
// Request channel of the region protection table: valid/ready plus command fields.
// Depends on rpt_pkg.
interface rpt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rpt_pkg::CMD_W-1:0]            command;
    logic [rpt_pkg::ADDR_BITS-1:0]        addr;
    logic [rpt_pkg::ADDR_BITS-1:0]        length;
    logic [rpt_pkg::PERM_W-1:0]           perm_bits;

    modport source (output valid, output command, output addr, output length,
                    output perm_bits, input ready);
    modport sink   (input valid, input command, input addr, input length,
                    input perm_bits, output ready);
endinterface

// ===== design/rpt_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the region protection table: valid/ready plus answer bits.
// No dependencies.
interface rpt_out_if;
    logic valid;
    logic ready;
    logic granted;
    logic full_res;

    modport source (output valid, output granted, output full_res, input ready);
    modport sink   (input valid, input granted, input full_res, output ready);
endinterface

// ===== design/rpt_cell.sv =====
`timescale 1ns / 1ps
// One table entry (base, end, flags) and one stage of the token chain.
// Depends on rpt_pkg.
module rpt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rpt_pkg::SLOT_W-1:0]  idx,
    input  rpt_pkg::tok_t               tok_in,
    output rpt_pkg::tok_t               tok_out
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [rpt_pkg::ADDR_BITS-1:0]   base_reg;
    logic [rpt_pkg::ADDR_BITS-1:0]   base_next;
    logic [rpt_pkg::LIM_W-1:0]       lim_reg;
    logic [rpt_pkg::LIM_W-1:0]       lim_next;
    logic [rpt_pkg::PERM_W-1:0]      perm_reg;
    logic [rpt_pkg::PERM_W-1:0]      perm_next;
    rpt_pkg::tok_t                   tok_reg;
    rpt_pkg::tok_t                   tok_next;

    logic base_eq;
    logic holds;
    logic overlap;

    assign base_eq = valid_reg && (base_reg == tok_in.addr);
    assign holds   = valid_reg && (tok_in.addr >= base_reg)
                     && ({1'b0, tok_in.addr} < lim_reg);
    // ranges are half-open; an empty range still overlaps one that holds it strictly inside
    assign overlap = valid_reg && ({1'b0, tok_in.addr} < lim_reg)
                     && ({1'b0, base_reg} < tok_in.lim);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        base_next  = base_reg;
        lim_next   = lim_reg;
        perm_next  = perm_reg;
        unique case (tok_in.op)
            rpt_pkg::OP_NONE:
            begin
            end
            rpt_pkg::OP_PROBE:
            begin
                if (overlap)
                    tok_next.hit = 1'b1;
                if (base_eq && !tok_in.match_ok)
                begin
                    tok_next.match_ok  = 1'b1;
                    tok_next.match_idx = idx;
                end
                if (!valid_reg && !tok_in.free_ok)
                begin
                    tok_next.free_ok  = 1'b1;
                    tok_next.free_idx = idx;
                end
            end
            rpt_pkg::OP_WRITE:
            begin
                if (idx == tok_in.match_idx)
                begin
                    valid_next = 1'b1;
                    base_next  = tok_in.addr;
                    lim_next   = tok_in.lim;
                    perm_next  = tok_in.perms;
                end
            end
            rpt_pkg::OP_REMOVE:
            begin
                if (base_eq)
                begin
                    valid_next   = 1'b0;
                    tok_next.hit = 1'b1;
                end
            end
            rpt_pkg::OP_CHECK:
            begin
                // first holder decides
                if (holds && !tok_in.hit)
                begin
                    tok_next.hit   = 1'b1;
                    tok_next.grant = ((perm_reg & tok_in.perms) == tok_in.perms);
                end
            end
            rpt_pkg::OP_QUERY:
            begin
                if (holds)
                    tok_next.hit = 1'b1;
            end
            rpt_pkg::OP_ALLOC:
            begin
                if (!valid_reg && !tok_in.hit)
                begin
                    valid_next   = 1'b1;
                    base_next    = tok_in.addr;
                    lim_next     = tok_in.lim;
                    perm_next    = tok_in.perms;
                    tok_next.hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        lim_reg  <= lim_next;
        perm_reg <= perm_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/rpt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: takes a request, launches tokens into the region or guard chain,
// decides the add-region write pass and holds the result for the output side.
// Depends on rpt_pkg, rpt_in_if, rpt_out_if.
module rpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    rpt_in_if.sink          request,
    rpt_out_if.source       result,
    output rpt_pkg::tok_t   rgn_head,
    output rpt_pkg::tok_t   grd_head,
    input  rpt_pkg::tok_t   rgn_tail,
    input  rpt_pkg::tok_t   grd_tail
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WAIT  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [rpt_pkg::CMD_W-1:0]    cmd_reg;
    logic [rpt_pkg::CMD_W-1:0]    cmd_next;
    rpt_pkg::tok_t                rgn_head_reg;
    rpt_pkg::tok_t                rgn_head_next;
    rpt_pkg::tok_t                grd_head_reg;
    rpt_pkg::tok_t                grd_head_next;
    logic                         res_granted_reg;
    logic                         res_granted_next;
    logic                         res_full_reg;
    logic                         res_full_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_granted_reg;
    logic                         out_granted_next;
    logic                         out_full_reg;
    logic                         out_full_next;

    rpt_pkg::tok_t                launch;
    rpt_pkg::tok_t                tail;
    logic                         accept;
    logic                         guard_cmd;

    assign accept    = request.valid && request.ready;
    assign guard_cmd = (cmd_reg == rpt_pkg::CMD_GUARD_QUERY)
                       || (cmd_reg == rpt_pkg::CMD_SET_GUARD)
                       || (cmd_reg == rpt_pkg::CMD_CLEAR_GUARD);
    assign tail      = guard_cmd ? grd_tail : rgn_tail;

    always_comb
    begin
        launch       = '0;
        launch.op    = rpt_pkg::OP_NONE;
        launch.addr  = request.addr;
        launch.lim   = {1'b0, request.addr} + {1'b0, request.length};
        launch.perms = request.perm_bits;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        rgn_head_next    = rgn_head_reg;
        rgn_head_next.op = rpt_pkg::OP_NONE;
        grd_head_next    = grd_head_reg;
        grd_head_next.op = rpt_pkg::OP_NONE;
        res_granted_next = res_granted_reg;
        res_full_next    = res_full_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_full_next    = out_full_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = request.command;
                    state_next = S_WAIT;
                    unique case (request.command)
                        rpt_pkg::CMD_ADD_REGION:
                        begin
                            rgn_head_next    = launch;
                            rgn_head_next.op = rpt_pkg::OP_PROBE;
                        end
                        rpt_pkg::CMD_REMOVE_REGION:
                        begin
                            rgn_head_next    = launch;
                            rgn_head_next.op = rpt_pkg::OP_REMOVE;
                        end
                        rpt_pkg::CMD_CHECK_ACCESS:
                        begin
                            rgn_head_next    = launch;
                            rgn_head_next.op = rpt_pkg::OP_CHECK;
                        end
                        rpt_pkg::CMD_GUARD_QUERY:
                        begin
                            grd_head_next    = launch;
                            grd_head_next.op = rpt_pkg::OP_QUERY;
                        end
                        rpt_pkg::CMD_SET_GUARD:
                        begin
                            grd_head_next    = launch;
                            grd_head_next.op = rpt_pkg::OP_ALLOC;
                        end
                        rpt_pkg::CMD_CLEAR_GUARD:
                        begin
                            grd_head_next    = launch;
                            grd_head_next.op = rpt_pkg::OP_REMOVE;
                        end
                        default:
                        begin
                            // unused codes: answer at once, touch nothing
                            res_granted_next = 1'b0;
                            res_full_next    = 1'b0;
                            state_next       = S_DONE;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (tail.op != rpt_pkg::OP_NONE)
                begin
                    state_next       = S_DONE;
                    res_granted_next = 1'b0;
                    res_full_next    = 1'b0;
                    unique case (cmd_reg)
                        rpt_pkg::CMD_ADD_REGION:
                        begin
                            if (!tail.hit && (tail.match_ok || tail.free_ok))
                            begin
                                // replace a same-base entry, else take first free slot
                                rgn_head_next.op        = rpt_pkg::OP_WRITE;
                                rgn_head_next.match_idx = tail.match_ok ? tail.match_idx
                                                                        : tail.free_idx;
                                state_next              = S_WRITE;
                            end
                            else if (!tail.hit)
                                res_full_next = 1'b1;
                        end
                        rpt_pkg::CMD_REMOVE_REGION: res_granted_next = tail.hit;
                        rpt_pkg::CMD_CHECK_ACCESS:  res_granted_next = tail.grant;
                        rpt_pkg::CMD_GUARD_QUERY:   res_granted_next = tail.hit;
                        rpt_pkg::CMD_SET_GUARD:
                        begin
                            res_granted_next = tail.hit;
                            res_full_next    = !tail.hit;
                        end
                        rpt_pkg::CMD_CLEAR_GUARD:   res_granted_next = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                if (rgn_tail.op != rpt_pkg::OP_NONE)
                begin
                    res_granted_next = 1'b1;
                    res_full_next    = 1'b0;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_full_next    = res_full_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rgn_head_reg  <= '0;
            grd_head_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rgn_head_reg  <= rgn_head_next;
            grd_head_reg  <= grd_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        res_granted_reg <= res_granted_next;
        res_full_reg    <= res_full_next;
        out_granted_reg <= out_granted_next;
        out_full_reg    <= out_full_next;
    end

    assign request.ready   = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.granted  = out_granted_reg;
    assign result.full_res = out_full_reg;
    assign rgn_head        = rgn_head_reg;
    assign grd_head        = grd_head_reg;

    a_one_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !((rgn_head_reg.op != rpt_pkg::OP_NONE) && (grd_head_reg.op != rpt_pkg::OP_NONE)))
        else $error("tokens launched into both chains at once");

    a_write_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        (rgn_head_reg.op == rpt_pkg::OP_WRITE) |-> (cmd_reg == rpt_pkg::CMD_ADD_REGION))
        else $error("write pass launched for a command other than add region");

    a_full_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && res_full_reg)
        |-> ((cmd_reg == rpt_pkg::CMD_ADD_REGION) || (cmd_reg == rpt_pkg::CMD_SET_GUARD)))
        else $error("full flag raised for a command that allocates nothing");

    a_tail_expected: assert property (@(posedge clk) disable iff (!rst_n)
        ((rgn_tail.op != rpt_pkg::OP_NONE) || (grd_tail.op != rpt_pkg::OP_NONE))
        |-> ((state_reg == S_WAIT) || (state_reg == S_WRITE)))
        else $error("token left a chain while no request was in flight");

    a_launch_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request did not start a pass");

endmodule

// ===== design/region_protection_table.sv =====
`timescale 1ns / 1ps
// Top level of the region protection table: sequencer plus the region and
// guard cell chains. Depends on rpt_pkg, rpt_in_if, rpt_out_if, rpt_cell, rpt_ctrl.
//
//  Port      Dir   Handshake     Carries
//  request   in    valid/ready   command, addr, length, perm_bits
//  result    out   valid/ready   granted, full_res
//
// One request at a time; it walks a chain one cell per cycle.
// Region remove/check take one pass down the region chain; region add takes a probe
// pass and a write pass; guard commands take one pass down the guard chain. Chain
// length sets how long each pass takes.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waiting on a stalled output does not block the next request until
// that request's own result is ready.
module region_protection_table (
    input  logic        clk,
    input  logic        rst_n,
    rpt_in_if.sink      request,
    rpt_out_if.source   result
);

    rpt_pkg::tok_t rgn_tok [rpt_pkg::REGION_SLOTS+1];
    rpt_pkg::tok_t grd_tok [rpt_pkg::GUARD_SLOTS+1];
    rpt_pkg::tok_t rgn_head;
    rpt_pkg::tok_t grd_head;

    rpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .result   (result),
        .rgn_head (rgn_head),
        .grd_head (grd_head),
        .rgn_tail (rgn_tok[rpt_pkg::REGION_SLOTS]),
        .grd_tail (grd_tok[rpt_pkg::GUARD_SLOTS])
    );

    assign rgn_tok[0] = rgn_head;
    assign grd_tok[0] = grd_head;

    for (genvar i = 0; i < rpt_pkg::REGION_SLOTS; i++)
    begin : g_rgn
        rpt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (rpt_pkg::SLOT_W'(i)),
            .tok_in  (rgn_tok[i]),
            .tok_out (rgn_tok[i+1])
        );
    end

    for (genvar j = 0; j < rpt_pkg::GUARD_SLOTS; j++)
    begin : g_grd
        rpt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (rpt_pkg::SLOT_W'(j)),
            .tok_in  (grd_tok[j]),
            .tok_out (grd_tok[j+1])
        );
    end

endmodule
